/* sv/csd_pkg.sv */
// shared types and constants for the checksummed serial deframer
package csd_pkg;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 9;
    localparam int SUM_W   = 16;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [STAT_W-1:0] STATUS_BUSY = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_GOOD = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_BAD  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_B = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0]  start_a;
        logic [BYTE_W-1:0]  start_b;
    } start_cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  frame_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               is_last;
        logic [STAT_W-1:0]  status;
        logic [SUM_W-1:0]   received_sum;
        logic [SUM_W-1:0]   computed_sum;
    } result_t;

endpackage

/* sv/checksummed_serial_deframer_unit.sv */
// top level of the checksummed serial deframer
// One received byte per request, one request per cycle sustained while the downstream takes
// each result; a stalled result stalls the input. A byte goes into an input register, the frame
// state machine decides on it and a frame byte lands in the result register. Bytes seen while
// hunting that match neither start byte are dropped without a result. The last byte of a frame
// carries status good or checksum error plus both sums; hunting resumes right after it.
module checksummed_serial_deframer_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [csd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [csd_pkg::BYTE_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [csd_pkg::BYTE_W-1:0]      rx_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [csd_pkg::BYTE_W-1:0]      frame_byte,
    output logic [csd_pkg::INDEX_W-1:0]     byte_index,
    output logic                            is_last,
    output logic [csd_pkg::STAT_W-1:0]      status,
    output logic [csd_pkg::SUM_W-1:0]       received_sum,
    output logic [csd_pkg::SUM_W-1:0]       computed_sum
);

    csd_pkg::start_cfg_t            start_cfg;
    csd_pkg::result_t               res;
    csd_pkg::result_t               res_reg;
    logic                           emit;
    logic                           s1_valid_reg;
    logic [csd_pkg::BYTE_W-1:0]     s1_byte_reg;
    logic                           out_valid_reg;
    logic                           out_free;
    logic                           consume;
    logic                           take_in;

    csd_cfg_regs u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start_cfg  (start_cfg)
    );

    csd_frame_fsm u_fsm
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (consume),
        .rx_byte    (s1_byte_reg),
        .start_cfg  (start_cfg),
        .emit       (emit),
        .res        (res)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign consume  = s1_valid_reg && (out_free || !emit);
    assign in_ready = !s1_valid_reg || consume;
    assign take_in  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (take_in)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (consume && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && emit)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_byte   = res_reg.frame_byte;
    assign byte_index   = res_reg.byte_index;
    assign is_last      = res_reg.is_last;
    assign status       = res_reg.status;
    assign received_sum = res_reg.received_sum;
    assign computed_sum = res_reg.computed_sum;

    // last byte always carries a final status, other bytes carry none
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_last == (status != csd_pkg::STATUS_BUSY)))
        else $error("status does not match last flag");

    // good status exactly when the two sums agree
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_last |->
            ((status == csd_pkg::STATUS_GOOD) == (received_sum == computed_sum)))
        else $error("status disagrees with checksum compare");

    // a frame ends no earlier than its command byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_last |-> byte_index >= 9'd4)
        else $error("frame ended inside its header");

    // result register holds while the downstream stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_index))
        else $error("pending result lost or changed");

endmodule

/* sv/csd_cfg_regs.sv */
// start byte configuration registers
module csd_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [csd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [csd_pkg::BYTE_W-1:0]      cfg_data,
    output csd_pkg::start_cfg_t             start_cfg
);

    csd_pkg::start_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                csd_pkg::CFG_START_A: cfg_reg.start_a <= cfg_data;
                csd_pkg::CFG_START_B: cfg_reg.start_b <= cfg_data;
                default: ;
            endcase
        end
    end

    assign start_cfg = cfg_reg;

endmodule

/* sv/csd_frame_fsm.sv */
// frame tracking state machine with checksum accumulation
module csd_frame_fsm
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [csd_pkg::BYTE_W-1:0]  rx_byte,
    input  csd_pkg::start_cfg_t         start_cfg,
    output logic                        emit,
    output csd_pkg::result_t            res
);

    typedef enum logic [2:0] {HUNT, SUM_LO, SUM_HI, LEN, CMD, DATA} state_t;

    state_t                         state_reg, state_next;
    logic [csd_pkg::BYTE_W-1:0]     length_reg, length_next;
    logic [csd_pkg::BYTE_W-1:0]     count_reg, count_next;
    logic [csd_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [csd_pkg::SUM_W-1:0]      hdr_reg, hdr_next;
    logic [csd_pkg::INDEX_W-1:0]    pos_reg, pos_next;
    logic [csd_pkg::INDEX_W-1:0]    idx;
    logic [csd_pkg::BYTE_W-1:0]     count_inc;
    logic [csd_pkg::SUM_W-1:0]      sum_inc;
    logic                           is_start;

    assign is_start  = (rx_byte == start_cfg.start_a) || (rx_byte == start_cfg.start_b);
    assign count_inc = count_reg + 8'd1;
    assign sum_inc   = sum_reg + {8'd0, rx_byte};
    assign idx       = (state_reg == HUNT) ? '0 : pos_reg;

    always_comb
    begin
        state_next  = state_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        hdr_next    = hdr_reg;
        emit        = 1'b1;
        res.frame_byte   = rx_byte;
        res.byte_index   = idx;
        res.is_last      = 1'b0;
        res.status       = csd_pkg::STATUS_BUSY;
        res.received_sum = '0;
        res.computed_sum = '0;
        unique case (state_reg)
            HUNT:
            begin
                emit = is_start;
                if (is_start)
                begin
                    state_next = SUM_LO;
                end
            end
            SUM_LO:
            begin
                hdr_next   = {8'd0, rx_byte};
                state_next = SUM_HI;
            end
            SUM_HI:
            begin
                hdr_next   = {rx_byte, hdr_reg[7:0]};
                state_next = LEN;
            end
            LEN:
            begin
                length_next = rx_byte;
                count_next  = '0;
                sum_next    = '0;
                state_next  = CMD;
            end
            CMD, DATA:
            begin
                count_next = count_inc;
                sum_next   = sum_inc;
                if (count_inc < length_reg)
                begin
                    state_next = DATA;
                end
                else
                begin
                    state_next       = HUNT;
                    res.is_last      = 1'b1;
                    res.status       = (sum_inc == hdr_reg) ? csd_pkg::STATUS_GOOD
                                                            : csd_pkg::STATUS_BAD;
                    res.received_sum = hdr_reg;
                    res.computed_sum = sum_inc;
                end
            end
            default:
            begin
                emit       = 1'b0;
                state_next = HUNT;
            end
        endcase
        pos_next = emit ? idx + 9'd1 : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= HUNT;
            length_reg <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            hdr_reg    <= '0;
            pos_reg    <= '0;
        end
        else if (step)
        begin
            state_reg  <= state_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            hdr_reg    <= hdr_next;
            pos_reg    <= pos_next;
        end
    end

endmodule
